// ===== rtl/lidar_packet_parser_macros.svh =====
`ifndef LIDAR_PACKET_PARSER_MACROS_SVH
`define LIDAR_PACKET_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LPP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpp_pkg;

  localparam int WIN_LEN    = 22;
  localparam int CHAIN_LEN  = WIN_LEN + 1;
  localparam int N_WORDS    = (WIN_LEN - 2) / 2;
  localparam int N_SAMPLES  = 4;
  localparam int SUM_W      = 26;
  localparam int CHK_W      = 15;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [7:0]       MARKER_RST = 8'd250;
  localparam logic [8:0]       OFFSET_RST = 9'd140;
  localparam logic [7:0]       INDEX_BASE = 8'hA0;
  localparam logic [CNT_W-1:0] FILL_FULL  = CNT_W'(WIN_LEN - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MARKER       = 1'b0,
    REG_ANGLE_OFFSET = 1'b1
  } cfg_reg_t;

  typedef logic [CHAIN_LEN-1:0][7:0] chain_t;

  typedef struct packed {
    logic [8:0]  angle;
    logic [15:0] distance;
    logic        warning;
    logic [15:0] strength;
    logic        sample_ok;
    logic [15:0] speed;
    logic        last;
  } sample_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  // Reduce 0..1534 to 0..359 with one bank of compares.
  function automatic logic [8:0] wrap_360(input logic [10:0] x);
    logic [10:0] r;
    priority if (x >= 11'd1440) begin
      r = x - 11'd1440;
    end else if (x >= 11'd1080) begin
      r = x - 11'd1080;
    end else if (x >= 11'd720) begin
      r = x - 11'd720;
    end else if (x >= 11'd360) begin
      r = x - 11'd360;
    end else begin
      r = x;
    end
    return r[8:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lpp_window.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpp_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift_en,
  input  logic [7:0]                byte_in,
  output lpp_pkg::chain_t           cells,
  output logic [lpp_pkg::SUM_W-1:0] sum
);
  import lpp_pkg::*;

  chain_t           cells_r, cells_nxt;
  logic [SUM_W-1:0] sum1_r, sum1_nxt;
  logic [SUM_W-1:0] sum2_r;
  logic [SUM_W-1:0] head_w, tail_w;

  // Byte cells: each takes its younger neighbor, the newest byte enters at the top.
  always_comb begin
    for (int i = 0; i < CHAIN_LEN - 1; i++) begin
      cells_nxt[i] = cells_r[i+1];
    end
    cells_nxt[CHAIN_LEN-1] = byte_in;
  end

  // Sliding shift-add sum, one chain per byte parity:
  // drop the oldest word (weight 2^10 after doubling), add the newest.
  always_comb begin
    head_w   = SUM_W'({cells_r[1], cells_r[0]}) << N_WORDS;
    tail_w   = SUM_W'({cells_r[WIN_LEN-1], cells_r[WIN_LEN-2]});
    sum1_nxt = (sum2_r << 1) - head_w + tail_w;
  end

  // Cells and sums reset together so the sum always matches the cells.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_r <= '0;
      sum1_r  <= '0;
      sum2_r  <= '0;
    end else if (shift_en) begin
      cells_r <= cells_nxt;
      sum2_r  <= sum1_r;
      sum1_r  <= sum1_nxt;
    end
  end

  assign cells = cells_r;
  assign sum   = sum1_r;

endmodule

`default_nettype wire

// ===== rtl/lpp_sample_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpp_sample_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  lpp_pkg::cell_ctl_t ctl,
  input  lpp_pkg::sample_t   load_data,
  input  lpp_pkg::sample_t   next_data,
  input  logic               next_valid,
  output lpp_pkg::sample_t   data,
  output logic               valid
);
  import lpp_pkg::*;

  sample_t data_r, data_nxt;
  logic    valid_r, valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    priority if (ctl.load) begin
      data_nxt  = load_data;
      valid_nxt = 1'b1;
    end else if (ctl.shift) begin
      data_nxt  = next_data;
      valid_nxt = next_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign data  = data_r;
  assign valid = valid_r;

endmodule

`default_nettype wire

// ===== rtl/lidar_packet_parser.sv =====
// Byte-serial parser for the 22-byte laser distance sensor packet.
// Input channel: in_valid / in_stall with in_data_byte, one sensor byte per item.
// Output channel: out_valid / out_stall, one sample per item, four per good packet,
// the fourth flagged by out_last.
// Config channel: cfg_valid / cfg_ready with cfg_index (0 marker, 1 angle offset)
// and cfg_data; cfg_ready is always high. Write only while the block is idle.
// Throughput: one byte per cycle while in_stall is low. The window is a chain of
// byte cells with a running shift-add sum, so a full window is checked in the cycle
// after its last byte. A passing check loads the four samples into a four-cell output
// chain at once, and they leave it one per cycle while out_stall is low.
// A stalled receiver holds the head sample; bytes keep flowing until a window
// check falls due while samples still wait, then in_stall rises until they drain.
// Reset (rst_n low at a clock edge) empties the window and the sample chain and
// restores marker 250 and angle offset 140.
`timescale 1ns / 1ps
`default_nettype none
`include "lidar_packet_parser_macros.svh"

module lidar_packet_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [8:0]                     out_angle,
  output logic [15:0]                    out_distance,
  output logic                           out_warning,
  output logic [15:0]                    out_strength,
  output logic                           out_sample_ok,
  output logic [15:0]                    out_speed,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lpp_pkg::*;

  logic [7:0]       marker_r, marker_nxt;
  logic [8:0]       offset_r, offset_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, eff_cnt;
  logic             chk_r, chk_nxt;
  logic             in_accept, good, pop, qbusy;
  chain_t           cells;
  logic [SUM_W-1:0] sum;
  logic [15:0]      fold, word10;
  logic [7:0]       base;
  logic [10:0]      angle_base;
  cell_ctl_t        ctl;
  sample_t          load_s [N_SAMPLES];
  sample_t          q_data [N_SAMPLES];
  logic [N_SAMPLES-1:0] q_valid;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_comb begin
    marker_nxt = marker_r;
    offset_nxt = offset_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MARKER:       marker_nxt = cfg_data[7:0];
        REG_ANGLE_OFFSET: offset_nxt = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= MARKER_RST;
      offset_r <= OFFSET_RST;
    end else begin
      marker_r <= marker_nxt;
      offset_r <= offset_nxt;
    end
  end

  lpp_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (in_accept),
    .byte_in  (in_data_byte),
    .cells    (cells),
    .sum      (sum)
  );

  // Window under check is cells[1..22]; fold the shift-add sum to 15 bits.
  always_comb begin
    word10 = {cells[CHAIN_LEN-1], cells[CHAIN_LEN-2]};
    fold   = {1'b0, sum[CHK_W-1:0]} + 16'(sum[SUM_W-1:CHK_W]);
    good   = chk_r && (cells[1] == marker_r) && !word10[15]
             && (fold[CHK_W-1:0] == word10[CHK_W-1:0]);
  end

  // A good packet empties the window; a bad one keeps it full.
  assign eff_cnt   = good ? '0 : cnt_r;
  assign qbusy     = |q_valid;
  assign in_stall  = qbusy && (eff_cnt == FILL_FULL);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    cnt_nxt = eff_cnt;
    chk_nxt = 1'b0;
    if (in_accept) begin
      if (eff_cnt == FILL_FULL) begin
        chk_nxt = 1'b1;
      end else begin
        cnt_nxt = eff_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      chk_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      chk_r <= chk_nxt;
    end
  end

  // Decode the four samples straight from the byte cells.
  assign base       = cells[2] - INDEX_BASE;
  assign angle_base = {1'b0, base, 2'b00} + {2'b00, offset_r};

  always_comb begin
    logic [15:0] dword;
    for (int n = 0; n < N_SAMPLES; n++) begin
      dword               = {cells[6+4*n], cells[5+4*n]};
      load_s[n].angle     = wrap_360(angle_base + 11'(n));
      load_s[n].distance  = dword[15] ? 16'hFFFF : {2'b00, dword[13:0]};
      load_s[n].warning   = dword[14];
      load_s[n].strength  = {cells[8+4*n], cells[7+4*n]};
      load_s[n].sample_ok = !dword[15] && !dword[14];
      load_s[n].speed     = {cells[4], cells[3]};
      load_s[n].last      = (n == N_SAMPLES - 1);
    end
  end

  // Output chain: load all cells at once, then advance one per taken item.
  assign pop       = q_valid[0] && !out_stall;
  assign ctl.load  = good;
  assign ctl.shift = pop;

  for (genvar g = 0; g < N_SAMPLES; g++) begin : g_cell
    sample_t nb_data;
    logic    nb_valid;
    if (g == N_SAMPLES - 1) begin : g_tail
      assign nb_data  = '0;
      assign nb_valid = 1'b0;
    end else begin : g_mid
      assign nb_data  = q_data[g+1];
      assign nb_valid = q_valid[g+1];
    end
    lpp_sample_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .load_data  (load_s[g]),
      .next_data  (nb_data),
      .next_valid (nb_valid),
      .data       (q_data[g]),
      .valid      (q_valid[g])
    );
  end

  assign out_valid     = q_valid[0];
  assign out_angle     = q_data[0].angle;
  assign out_distance  = q_data[0].distance;
  assign out_warning   = q_data[0].warning;
  assign out_strength  = q_data[0].strength;
  assign out_sample_ok = q_data[0].sample_ok;
  assign out_speed     = q_data[0].speed;
  assign out_last      = q_data[0].last;

  `LPP_ASSERT_IMP(a_load_into_empty, clk, rst_n, good, !qbusy, "packet loaded over waiting samples")
  `LPP_ASSERT_NXT(a_load_fills_all, clk, rst_n, good, &q_valid, "packet load did not fill chain")
  `LPP_ASSERT_IMP(a_check_when_full, clk, rst_n, chk_r, cnt_r == FILL_FULL, "check without full window")
  `LPP_ASSERT_NXT(a_last_drains, clk, rst_n, pop && out_last, !qbusy, "samples left after last")

endmodule

`default_nettype wire

// ===== tb/sv/tb_lidar_packet_parser.sv =====
`timescale 1ns / 1ps

module tb_lidar_packet_parser;

  import lpp_pkg::*;

  localparam int FRAME_LEN   = 22;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 8;
  localparam int ITEM_TOTAL  = 410;
  localparam int EXP_DEPTH   = 16;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_SUM,
    FRAME_SUM_MSB,
    FRAME_BAD_MARKER
  } frame_kind_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_data_byte = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [8:0]            out_angle;
  logic [15:0]           out_distance;
  logic                  out_warning;
  logic [15:0]           out_strength;
  logic                  out_sample_ok;
  logic [15:0]           out_speed;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the parser state
  frame_t      win_bytes;
  int unsigned fill_level;
  logic [7:0]  cur_marker;
  logic [8:0]  cur_offset;

  // Expected samples, in order, as a small ring
  sample_t     exp_ring [EXP_DEPTH];
  int unsigned exp_wr;
  int unsigned exp_rd;
  frame_t      frame_buf;
  int unsigned mismatch_count;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  bit          steady_flow;

  lidar_packet_parser i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_angle     (out_angle),
    .out_distance  (out_distance),
    .out_warning   (out_warning),
    .out_strength  (out_strength),
    .out_sample_ok (out_sample_ok),
    .out_speed     (out_speed),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int unsigned exp_count();
    return exp_wr - exp_rd;
  endfunction

  function automatic void exp_add(input sample_t s);
    exp_ring[exp_wr % EXP_DEPTH] = s;
    exp_wr++;
  endfunction

  // Folded shift-add over the ten leading little-endian words
  function automatic logic [14:0] fold_checksum(input frame_t f);
    logic [31:0] acc;
    logic [31:0] folded;
    acc = '0;
    for (int k = 0; k < 10; k++) begin
      acc = (acc << 1) + {16'h0000, f[2*k+1], f[2*k]};
    end
    folded = (acc & 32'h7FFF) + (acc >> 15);
    return folded[14:0];
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    logic [7:0]  base;
    logic [15:0] dist_word;
    sample_t     s;
    int unsigned pos;
    if (fill_level >= FRAME_LEN) fill_level = FRAME_LEN - 1;
    win_bytes[fill_level] = b;
    fill_level++;
    if (fill_level < FRAME_LEN) return;
    if (win_bytes[0] != cur_marker ||
        {win_bytes[21], win_bytes[20]} != {1'b0, fold_checksum(win_bytes)}) begin
      // drop the oldest byte, resume the search one position later
      win_bytes = win_bytes >> 8;
      fill_level = FRAME_LEN - 1;
      return;
    end
    base = win_bytes[1] - INDEX_BASE;
    for (int n = 0; n < 4; n++) begin
      pos = 4 + 4 * n;
      dist_word = {win_bytes[pos+1], win_bytes[pos]};
      s.angle = 9'((int'(base) * 4 + n + int'(cur_offset)) % 360);
      s.distance = dist_word[15] ? 16'hFFFF : (dist_word & 16'h3FFF);
      s.warning = dist_word[14];
      s.strength = {win_bytes[pos+3], win_bytes[pos+2]};
      s.sample_ok = (s.distance != 16'hFFFF) && !s.warning;
      s.speed = {win_bytes[3], win_bytes[2]};
      s.last = (n == 3);
      exp_add(s);
    end
    fill_level = 0;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_samples
    sample_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_count() == 0) begin
        $display("%0t: unexpected sample, expected none actual angle %0d distance %0d",
                 $time, out_angle, out_distance);
        mismatch_count++;
      end else begin
        want = exp_ring[exp_rd % EXP_DEPTH];
        exp_rd++;
        check_field("angle", want.angle, out_angle);
        check_field("distance", want.distance, out_distance);
        check_field("warning", want.warning, out_warning);
        check_field("strength", want.strength, out_strength);
        check_field("sample_ok", want.sample_ok, out_sample_ok);
        check_field("speed", want.speed, out_speed);
        check_field("last", want.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d samples outstanding", $time, exp_count());
      $display("lidar_packet_parser test failed");
      $finish;
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    out_stall <= !steady_flow && ($urandom_range(99) < 31);
  end

  task automatic send_byte(input logic [7:0] b);
    while (!steady_flow && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    parse_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int unsigned count);
    for (int i = 0; i < count; i++) send_byte(frame_buf[i]);
  endtask

  task automatic fill_frame(input logic [7:0] mark);
    for (int i = 0; i < FRAME_LEN; i++) frame_buf[i] = 8'($urandom);
    frame_buf[0] = mark;
  endtask

  task automatic seal_frame(input frame_kind_t kind);
    logic [14:0] sum;
    if (kind == FRAME_BAD_MARKER) frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(1, 255));
    sum = fold_checksum(frame_buf);
    frame_buf[20] = sum[7:0];
    frame_buf[21] = {1'b0, sum[14:8]};
    if (kind == FRAME_BAD_SUM) frame_buf[20] = frame_buf[20] ^ 8'($urandom_range(1, 255));
    if (kind == FRAME_SUM_MSB) frame_buf[21][7] = 1'b1;
  endtask

  task automatic random_frame(input frame_kind_t kind);
    fill_frame(cur_marker);
    seal_frame(kind);
    send_frame(FRAME_LEN);
  endtask

  // Hold the input, let outstanding samples drain and the last check settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (exp_count() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_MARKER) cur_marker = value[7:0];
    else cur_offset = value;
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [7:0] mark, input logic [8:0] offset);
    wait_idle();
    write_reg(REG_MARKER, {1'b0, mark});
    write_reg(REG_ANGLE_OFFSET, offset);
    cfg_valid <= 1'b0;
  endtask

  // Partial window yields nothing; its last byte then completes the frame, and a full frame with reset settings follows
  task automatic test_window_fill();
    fill_frame(cur_marker);
    seal_frame(FRAME_GOOD);
    send_frame(FRAME_LEN - 1);
    wait_idle();
    send_byte(frame_buf[FRAME_LEN-1]);
    random_frame(FRAME_GOOD);
  endtask

  task automatic test_sample_fields();
    fill_frame(cur_marker);
    frame_buf[1] = 8'h9F;
    {frame_buf[3], frame_buf[2]} = 16'hFFFF;
    {frame_buf[5], frame_buf[4]} = 16'h8000;
    {frame_buf[7], frame_buf[6]} = 16'hFFFF;
    {frame_buf[9], frame_buf[8]} = 16'h7FFF;
    {frame_buf[11], frame_buf[10]} = 16'h0000;
    {frame_buf[13], frame_buf[12]} = 16'h0000;
    {frame_buf[17], frame_buf[16]} = 16'h3FFF;
    seal_frame(FRAME_GOOD);
    send_frame(FRAME_LEN);
    fill_frame(cur_marker);
    frame_buf[1] = INDEX_BASE;
    {frame_buf[3], frame_buf[2]} = 16'h0000;
    {frame_buf[5], frame_buf[4]} = 16'hC000;
    seal_frame(FRAME_GOOD);
    send_frame(FRAME_LEN);
  endtask

  task automatic test_rejected_frames();
    random_frame(FRAME_SUM_MSB);
    random_frame(FRAME_GOOD);
    random_frame(FRAME_BAD_SUM);
    random_frame(FRAME_BAD_MARKER);
    random_frame(FRAME_GOOD);
  endtask

  task automatic test_register_sweep();
    set_regs(8'h00, 9'd0);
    random_frame(FRAME_GOOD);
    set_regs(8'hFF, 9'd359);
    fill_frame(cur_marker);
    frame_buf[1] = 8'h9F;
    seal_frame(FRAME_GOOD);
    send_frame(FRAME_LEN);
    // offset beyond a full turn still wraps
    set_regs(8'h5A, 9'd511);
    fill_frame(cur_marker);
    frame_buf[1] = 8'h9F;
    seal_frame(FRAME_GOOD);
    send_frame(FRAME_LEN);
    random_frame(FRAME_GOOD);
    set_regs(MARKER_RST, OFFSET_RST);
  endtask

  task automatic test_steady_flow();
    steady_flow = 1'b1;
    repeat (2) random_frame(FRAME_GOOD);
    send_byte(8'($urandom));
    random_frame(FRAME_GOOD);
    steady_flow = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned next_cfg;
    int unsigned pick;
    start = bytes_sent;
    next_cfg = 20;
    while (bytes_sent < ITEM_TOTAL) begin
      if (bytes_sent - start >= next_cfg) begin
        set_regs(8'($urandom), 9'($urandom_range(0, 511)));
        next_cfg += 20;
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else if (pick < 15) begin
        // abandon a frame part way through
        fill_frame(cur_marker);
        seal_frame(FRAME_GOOD);
        send_frame($urandom_range(1, FRAME_LEN - 1));
      end else if (pick < 28) begin
        random_frame(frame_kind_t'($urandom_range(FRAME_BAD_SUM, FRAME_BAD_MARKER)));
      end else begin
        random_frame(FRAME_GOOD);
      end
    end
  endtask

  initial begin
    win_bytes = '0;
    fill_level = 0;
    cur_marker = MARKER_RST;
    cur_offset = OFFSET_RST;
    exp_wr = 0;
    exp_rd = 0;
    mismatch_count = 0;
    bytes_sent = 0;
    cycle_count = 0;
    steady_flow = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_window_fill();
    test_sample_fields();
    test_rejected_frames();
    test_register_sweep();
    test_steady_flow();
    test_random_traffic();
    wait_idle();
    repeat (16) @(negedge clk);
    if (mismatch_count == 0 && exp_count() == 0) begin
      $display("lidar_packet_parser test passed");
    end else begin
      $display("lidar_packet_parser test failed");
    end
    $finish;
  end

endmodule
